// ----- rtl/bgmc_pkg.sv -----
// Shared types, constants and helper functions of the barrier gate motor controller.
// Used by every module of the block; depends on nothing.
package bgmc_pkg;

    localparam int TIME_WIDTH = 16;
    localparam int EL_W       = TIME_WIDTH + 1;
    localparam int CFG_W      = 16;
    localparam int EFF_W      = (EL_W > CFG_W) ? EL_W : CFG_W;
    localparam int DIVD_W     = 2 * EFF_W;
    localparam int CNT_W      = $clog2(DIVD_W + 1);

    localparam logic [TIME_WIDTH-1:0] TIME_MAX    = '1;
    localparam logic [EL_W-1:0]       ELAPSED_MAX = '1;

    localparam logic [31:0] STUCK_MARGIN = 32'd2000;
    localparam logic [31:0] LEARN_LIMIT  = 32'd60000;
    localparam logic [31:0] MIN_REVERSE  = 32'd100;
    localparam logic [31:0] FULL_PCT     = 32'd100;

    localparam logic [2:0] M_IDLE    = 3'd0;
    localparam logic [2:0] M_OPENING = 3'd1;
    localparam logic [2:0] M_OPEN    = 3'd2;
    localparam logic [2:0] M_CLOSING = 3'd3;
    localparam logic [2:0] M_ERROR   = 3'd4;

    localparam logic [1:0] F_NONE        = 2'd0;
    localparam logic [1:0] F_BOTH_LIMITS = 2'd1;
    localparam logic [1:0] F_STUCK_OPEN  = 2'd2;
    localparam logic [1:0] F_STUCK_CLOSE = 2'd3;

    localparam logic [1:0] RLY_OFF  = 2'd0;
    localparam logic [1:0] RLY_UP   = 2'd1;
    localparam logic [1:0] RLY_DOWN = 2'd2;

    localparam logic [2:0] CFG_OPEN_TIME  = 3'd0;
    localparam logic [2:0] CFG_CLOSE_TIME = 3'd1;
    localparam logic [2:0] CFG_OPEN_HOLD  = 3'd2;
    localparam logic [2:0] CFG_LOOP_POL   = 3'd3;
    localparam logic [2:0] CFG_DEAD_TIME  = 3'd4;

    typedef struct packed {
        logic load;
        logic tick;
        logic mul_rev;
        logic mul_pos;
        logic div_start;
        logic apply;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic need_rev;
        logic div_done;
    } dp_stat_t;

    function automatic logic [TIME_WIDTH-1:0] cap_time(input logic [31:0] t);
        logic [31:0] m;
        m = 32'(TIME_MAX);
        return (t > m) ? TIME_MAX : t[TIME_WIDTH-1:0];
    endfunction

    function automatic logic [EFF_W-1:0] eff_time(input logic [EL_W-1:0] learned,
                                                  input logic [CFG_W-1:0] cfg);
        logic [EFF_W-1:0] t;
        t = (learned != '0) ? EFF_W'(learned) : EFF_W'(cfg);
        return (t != '0) ? t : EFF_W'(1);
    endfunction

endpackage

// ----- rtl/barrier_gate_motor_controller.sv -----
// Barrier gate motor controller top level: one request per 1 ms tick, one result each.
// Each tick runs a position divide, plus a reversal divide when a closing barrier is
// reversed (serial divider, 34 steps). A new request is taken only once the last is
// finished; the next is taken while a result waits downstream.
// Reset (rst_n, asynchronous, low): idle mode, relays off, default configuration loaded.
// Depends on bgmc_pkg, bgmc_ctrl, bgmc_dp and bgmc_div.
module barrier_gate_motor_controller (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // button_one, button_two, loop_pin, up_limit, down_limit, pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // drive_up, drive_down, indicator, mode[3], fault[2],
                                        // position[7], hold_left_ms[16], learned_up_ms[16],
                                        // learned_down_ms[16], timed_finish
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import bgmc_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    bgmc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bgmc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .pins_in   (s_axis_tdata[4:0]),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (m_axis_tdata)
    );

endmodule

// ----- rtl/bgmc_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
// Depends on bgmc_pkg for its operand widths.
module bgmc_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [bgmc_pkg::DIVD_W-1:0]  dividend,
    input  logic [bgmc_pkg::EFF_W-1:0]   divisor,
    output logic                         done,
    output logic [bgmc_pkg::DIVD_W-1:0]  quotient
);
    import bgmc_pkg::*;

    logic [EFF_W-1:0]  rem_reg, rem_next;
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [EFF_W:0]    trial;
    logic              fits;

    assign trial = {rem_reg, quo_reg[DIVD_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CNT_W'(DIVD_W);
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? EFF_W'(trial - {1'b0, divisor}) : trial[EFF_W-1:0];
            quo_next = {quo_reg[DIVD_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/bgmc_dp.sv -----
// Datapath: gate state, timers, relay interlock, configuration and result register.
// Depends on bgmc_pkg and bgmc_div.
module bgmc_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  bgmc_pkg::dp_cmd_t  cmd,
    output bgmc_pkg::dp_stat_t stat,
    input  logic [4:0]         pins_in,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output logic [63:0]        out_data
);
    import bgmc_pkg::*;

    localparam int TW = TIME_WIDTH;

    logic [15:0]       open_t_reg, close_t_reg, hold_t_reg;
    logic              loop_pol_reg;
    logic [9:0]        dead_reg;

    logic [2:0]        mode_reg, mode_next;
    logic [TW-1:0]     tl_reg, tl_next, tp_reg, tp_next;
    logic              run_reg, run_next;
    logic [EL_W-1:0]   me_reg, me_next;
    logic [TW-1:0]     hl_reg, hl_next;
    logic [EL_W-1:0]   lu_reg, lu_next, ld_reg, ld_next;
    logic [1:0]        rs_reg, rs_next;
    logic              pend_reg, pend_next;
    logic [TW-1:0]     ss_reg, ss_next;
    logic              ind_reg, ind_next;
    logic              timed_reg, timed_next;
    logic [1:0]        fault_reg, fault_next;
    logic [4:0]        last_reg, last_next;
    logic              pv_reg, pv_next;
    logic [4:0]        pins_reg;
    logic [63:0]       out_reg, out_next;
    logic [DIVD_W-1:0] prod_reg;
    logic [EFF_W-1:0]  dsor_reg;
    logic [DIVD_W-1:0] quo;
    logic              div_done;

    logic [4:0]        chg;
    logic              la, req;
    logic [EFF_W-1:0]  up_t, dn_t, e_clip;

    assign chg   = pv_reg ? (pins_reg ^ last_reg) : 5'h1f;
    assign la    = (pins_reg[2] == loop_pol_reg);
    assign req   = (chg[0] && !pins_reg[0]) || (chg[1] && !pins_reg[1])
                   || (chg[2] && la && pins_reg[4]);
    assign up_t  = eff_time(lu_reg, open_t_reg);
    assign dn_t  = eff_time(ld_reg, close_t_reg);
    assign e_clip = (32'(me_reg) > 32'(dn_t)) ? dn_t : EFF_W'(me_reg);

    assign stat = {req && (mode_reg == M_CLOSING), div_done};

    bgmc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (dsor_reg),
        .done     (div_done),
        .quotient (quo)
    );

    always_comb
    begin
        logic [2:0]       m;
        logic [TW-1:0]    tl, tp, hl, ss, hout;
        logic             run, pend, ind, timed, upc, dnc, up, dn;
        logic [EL_W-1:0]  me, lu, ld;
        logic [1:0]       rs, flt, want;
        logic [EFF_W-1:0] eo, rem, tgt;
        logic [6:0]       pos;
        logic             do_set;

        m = mode_reg; tl = tl_reg; tp = tp_reg; run = run_reg; me = me_reg;
        hl = hl_reg; lu = lu_reg; ld = ld_reg; rs = rs_reg; pend = pend_reg;
        ss = ss_reg; ind = ind_reg; timed = timed_reg; flt = fault_reg;
        up = pins_reg[3]; dn = pins_reg[4];
        upc = chg[3]; dnc = chg[4];
        hout = '0; pos = '0; want = RLY_OFF; do_set = 1'b0;
        eo = quo[EFF_W-1:0]; rem = up_t - eo; tgt = '0;
        last_next = last_reg; pv_next = pv_reg; out_next = out_reg;

        if (cmd.tick)
        begin
            if (ss < TIME_MAX) ss = ss + TW'(1);
            if (me < ELAPSED_MAX) me = me + EL_W'(1);
            if (hl != '0) hl = hl - TW'(1);
            if (run)
            begin
                if (tl != '0) tl = tl - TW'(1);
                if (tl == '0)
                begin
                    run = 1'b0;
                    flt = F_NONE;
                    case (m)
                        M_OPENING:
                        begin
                            m = M_OPEN;
                            hl = cap_time(32'(hold_t_reg));
                            rs = RLY_OFF; pend = 1'b0;
                            tp = cap_time(32'(hold_t_reg));
                            tl = (tp != '0) ? tp : TW'(1); run = 1'b1;
                            timed = 1'b1;
                        end
                        M_OPEN:
                        begin
                            if (!la)
                            begin
                                m = M_CLOSING;
                                do_set = 1'b1; want = RLY_DOWN;
                                me = '0; timed = 1'b0;
                                tp = cap_time(32'(close_t_reg));
                                tl = (tp != '0) ? tp : TW'(1); run = 1'b1;
                            end
                            else
                            begin
                                hl = cap_time(32'(hold_t_reg));
                                tl = (tp != '0) ? tp : TW'(1); run = 1'b1;
                            end
                        end
                        M_CLOSING:
                        begin
                            m = M_IDLE;
                            rs = RLY_OFF; pend = 1'b0;
                            timed = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            if (do_set && rs != want)
            begin
                if (rs != RLY_OFF)
                begin
                    if (32'(ss) >= 32'(dead_reg)) begin rs = RLY_OFF; ss = '0; end
                    pend = 1'b1;
                end
                else
                begin
                    rs = want; ss = '0; pend = 1'b0;
                end
            end
            if (pend && 32'(ss) >= 32'(dead_reg))
            begin
                if (m == M_OPENING && !rs[0])
                begin
                    if (rs[1]) begin rs = RLY_OFF; ss = '0; end
                    else begin rs = RLY_UP; pend = 1'b0; end
                end
                else if (m == M_CLOSING && !rs[1])
                begin
                    if (rs[0]) begin rs = RLY_OFF; ss = '0; end
                    else begin rs = RLY_DOWN; pend = 1'b0; end
                end
                else
                begin
                    pend = 1'b0;
                end
            end
        end

        if (cmd.apply)
        begin
            if (req)
            begin
                flt = F_NONE;
                if (m != M_ERROR && m != M_OPENING)
                begin
                    hl = cap_time(32'(hold_t_reg));
                    if (m == M_OPEN)
                    begin
                        tl = (tp != '0) ? tp : TW'(1); run = 1'b1;
                    end
                    else
                    begin
                        if (m == M_CLOSING)
                        begin
                            me = EL_W'(eo);
                            tgt = (32'(rem) < MIN_REVERSE) ? EFF_W'(MIN_REVERSE) : rem;
                        end
                        else
                        begin
                            me = '0;
                            tgt = up_t;
                        end
                        tp = cap_time(32'(tgt));
                        tl = (tp != '0) ? tp : TW'(1); run = 1'b1;
                        m = M_OPENING;
                        timed = 1'b0;
                        if (rs != RLY_UP)
                        begin
                            if (rs != RLY_OFF)
                            begin
                                if (32'(ss) >= 32'(dead_reg)) begin rs = RLY_OFF; ss = '0; end
                                pend = 1'b1;
                            end
                            else
                            begin
                                rs = RLY_UP; ss = '0; pend = 1'b0;
                            end
                        end
                    end
                end
            end
            if (chg[2] && !la)
            begin
                hl = cap_time(32'(hold_t_reg));
                tl = (tp != '0) ? tp : TW'(1); run = 1'b1;
            end
            if ((upc || dnc) && m == M_ERROR)
            begin
                upc = 1'b1; dnc = 1'b1;
            end
            if (upc)
            begin
                if (!up && dn)
                begin
                    ind = 1'b1; flt = F_NONE;
                    if (m != M_CLOSING)
                    begin
                        if (me != '0 && 32'(me) < LEARN_LIMIT) lu = me;
                        m = M_OPEN;
                        hl = cap_time(32'(hold_t_reg));
                        rs = RLY_OFF; pend = 1'b0;
                        tp = cap_time(32'(hold_t_reg));
                        tl = (tp != '0) ? tp : TW'(1); run = 1'b1;
                    end
                end
                if (!up && !dn)
                begin
                    flt = F_BOTH_LIMITS; rs = RLY_OFF; pend = 1'b0; run = 1'b0; m = M_ERROR;
                end
            end
            if (dnc)
            begin
                if (!dn && up)
                begin
                    ind = 1'b0; flt = F_NONE;
                    if (m == M_CLOSING)
                    begin
                        if (me != '0 && 32'(me) < LEARN_LIMIT) ld = me;
                        m = M_IDLE; rs = RLY_OFF; pend = 1'b0; run = 1'b0;
                    end
                    else if (m != M_OPENING)
                    begin
                        m = M_IDLE; rs = RLY_OFF; pend = 1'b0;
                    end
                end
                if (!up && !dn)
                begin
                    flt = F_BOTH_LIMITS; rs = RLY_OFF; pend = 1'b0; run = 1'b0; m = M_ERROR;
                end
            end
            last_next = pins_reg;
            pv_next   = 1'b1;
        end

        if (cmd.finish)
        begin
            case (m)
                M_OPEN:    pos = 7'(FULL_PCT);
                M_OPENING: pos = (32'(quo) > FULL_PCT) ? 7'(FULL_PCT) : quo[6:0];
                M_CLOSING: pos = (32'(quo) > FULL_PCT) ? 7'd0 : 7'(FULL_PCT) - quo[6:0];
                default:   pos = '0;
            endcase
            if (flt == F_NONE)
            begin
                if (m == M_OPEN && !la)
                begin
                    hout = hl;
                end
                else if (m == M_OPENING && up
                         && 32'(me) > 32'(open_t_reg) + STUCK_MARGIN)
                begin
                    flt = F_STUCK_OPEN; rs = RLY_OFF; pend = 1'b0; run = 1'b0; m = M_ERROR;
                end
                else if (m == M_CLOSING && dn && !la
                         && 32'(me) > 32'(close_t_reg) + STUCK_MARGIN)
                begin
                    flt = F_STUCK_CLOSE; rs = RLY_OFF; pend = 1'b0; run = 1'b0; m = M_ERROR;
                end
            end
            out_next = {timed, 16'(ld), 16'(lu), 16'(hout), pos, flt, m, ind, rs[1], rs[0]};
        end

        mode_next = m; tl_next = tl; tp_next = tp; run_next = run; me_next = me;
        hl_next = hl; lu_next = lu; ld_next = ld; rs_next = rs; pend_next = pend;
        ss_next = ss; ind_next = ind; timed_next = timed; fault_next = flt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_t_reg   <= 16'd5000;
            close_t_reg  <= 16'd5000;
            hold_t_reg   <= 16'd10000;
            loop_pol_reg <= 1'b0;
            dead_reg     <= 10'd50;
            mode_reg     <= M_IDLE;
            tl_reg       <= '0;
            tp_reg       <= cap_time(32'd5000);
            run_reg      <= 1'b0;
            me_reg       <= '0;
            hl_reg       <= '0;
            lu_reg       <= '0;
            ld_reg       <= '0;
            rs_reg       <= RLY_OFF;
            pend_reg     <= 1'b0;
            ss_reg       <= TIME_MAX;
            ind_reg      <= 1'b0;
            timed_reg    <= 1'b0;
            fault_reg    <= F_NONE;
            last_reg     <= '0;
            pv_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_OPEN_TIME:  open_t_reg   <= cfg_data;
                    CFG_CLOSE_TIME: close_t_reg  <= cfg_data;
                    CFG_OPEN_HOLD:  hold_t_reg   <= cfg_data;
                    CFG_LOOP_POL:   loop_pol_reg <= cfg_data[0];
                    CFG_DEAD_TIME:  dead_reg     <= cfg_data[9:0];
                    default: ;
                endcase
            end
            mode_reg  <= mode_next;
            tl_reg    <= tl_next;
            tp_reg    <= tp_next;
            run_reg   <= run_next;
            me_reg    <= me_next;
            hl_reg    <= hl_next;
            lu_reg    <= lu_next;
            ld_reg    <= ld_next;
            rs_reg    <= rs_next;
            pend_reg  <= pend_next;
            ss_reg    <= ss_next;
            ind_reg   <= ind_next;
            timed_reg <= timed_next;
            fault_reg <= fault_next;
            last_reg  <= last_next;
            pv_reg    <= pv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            pins_reg <= pins_in;
        if (cmd.mul_rev)
        begin
            prod_reg <= DIVD_W'(e_clip) * DIVD_W'(up_t);
            dsor_reg <= dn_t;
        end
        else if (cmd.mul_pos)
        begin
            prod_reg <= DIVD_W'(me_reg) * DIVD_W'(FULL_PCT);
            dsor_reg <= (mode_reg == M_OPENING) ? up_t : dn_t;
        end
        out_reg <= out_next;
    end

    assign out_data = out_reg;

endmodule

// ----- rtl/bgmc_ctrl.sv -----
// Sequencer for one tick: update, optional reversal divide, apply, position divide, result.
// Depends on bgmc_pkg.
module bgmc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  bgmc_pkg::dp_stat_t stat,
    output bgmc_pkg::dp_cmd_t  cmd
);
    import bgmc_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_TICK   = 10'b0000000010,
        S_RMUL   = 10'b0000000100,
        S_RSTART = 10'b0000001000,
        S_RWAIT  = 10'b0000010000,
        S_APPLY  = 10'b0000100000,
        S_PMUL   = 10'b0001000000,
        S_PSTART = 10'b0010000000,
        S_PWAIT  = 10'b0100000000,
        S_FINISH = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;
    logic   room;

    assign room = !ov_reg || out_ready;

    always_comb
    begin
        cmd.load      = (state_reg == S_IDLE) && in_valid;
        cmd.tick      = (state_reg == S_TICK);
        cmd.mul_rev   = (state_reg == S_RMUL);
        cmd.mul_pos   = (state_reg == S_PMUL);
        cmd.div_start = (state_reg == S_RSTART) || (state_reg == S_PSTART);
        cmd.apply     = (state_reg == S_APPLY);
        cmd.finish    = (state_reg == S_FINISH) && room;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_TICK;
            S_TICK:   state_next = S_RMUL;
            S_RMUL:   state_next = stat.need_rev ? S_RSTART : S_APPLY;
            S_RSTART: state_next = S_RWAIT;
            S_RWAIT:  if (stat.div_done) state_next = S_APPLY;
            S_APPLY:  state_next = S_PMUL;
            S_PMUL:   state_next = S_PSTART;
            S_PSTART: state_next = S_PWAIT;
            S_PWAIT:  if (stat.div_done) state_next = S_FINISH;
            S_FINISH: if (room) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
        ov_next = cmd.finish ? 1'b1 : (out_ready ? 1'b0 : ov_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state register not one-hot");
    a_accept_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_TICK))
        else $error("accepted request not followed by tick update");
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid)
        else $error("finished request not presented");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!ov_reg || out_ready))
        else $error("result overwritten before taken");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for barrier_gate_motor_controller: drives 1 ms ticks and
// settings writes, predicts every status word and checks it. Depends on bgmc_pkg.
module testbench;
    import bgmc_pkg::*;

    typedef struct {
        bit        drive_up;
        bit        drive_down;
        bit        indicator;
        bit [2:0]  mode;
        bit [1:0]  fault;
        bit [6:0]  position;
        bit [15:0] hold_left;
        bit [15:0] learned_up;
        bit [15:0] learned_down;
        bit        timed_finish;
    } gate_status_t;

    class gate_scoreboard;
        int unsigned open_t, close_t, hold_t, loop_pol, dead_t;
        int unsigned mode_q, tmr_left, tmr_period, tmr_run, elapsed, hold_q;
        int unsigned lrn_up, lrn_dn, relays, pending, since_sw;
        int unsigned ind_q, timed_q, fault_q, last_pins, pins_seen;
        gate_status_t status_q[$];
        int errors;
        int checked;

        function new();
            open_t = 5000; close_t = 5000; hold_t = 10000; loop_pol = 0; dead_t = 50;
            mode_q = M_IDLE; tmr_left = 0; tmr_period = 5000; tmr_run = 0; elapsed = 0;
            hold_q = 0; lrn_up = 0; lrn_dn = 0; relays = RLY_OFF; pending = 0;
            since_sw = 65535; ind_q = 0; timed_q = 0; fault_q = F_NONE;
            last_pins = 0; pins_seen = 0; errors = 0; checked = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                CFG_OPEN_TIME:  open_t = 32'(val);
                CFG_CLOSE_TIME: close_t = 32'(val);
                CFG_OPEN_HOLD:  hold_t = 32'(val);
                CFG_LOOP_POL:   loop_pol = 32'(val[0]);
                CFG_DEAD_TIME:  dead_t = 32'(val[9:0]);
                default: ;
            endcase
        endfunction

        function int unsigned clamp16(int unsigned t);
            return (t > 65535) ? 65535 : t;
        endfunction

        function int unsigned travel(int unsigned lrn, int unsigned cfg);
            int unsigned t;
            t = (lrn != 0) ? lrn : cfg;
            return (t != 0) ? t : 1;
        endfunction

        function void restart_timer();
            tmr_left = (tmr_period != 0) ? tmr_period : 1;
            tmr_run = 1;
        endfunction

        function void start_timer(int unsigned p);
            tmr_period = clamp16(p);
            restart_timer();
        endfunction

        function void relays_off();
            relays = RLY_OFF;
            pending = 0;
        endfunction

        function void drive(int unsigned want);
            if (relays == want)
                return;
            if (relays != RLY_OFF)
            begin
                if (since_sw >= dead_t)
                begin
                    relays = RLY_OFF;
                    since_sw = 0;
                end
                pending = 1;
                return;
            end
            relays = want;
            since_sw = 0;
            pending = 0;
        endfunction

        function void trip(int unsigned code);
            fault_q = code;
            relays_off();
            tmr_run = 0;
            mode_q = M_ERROR;
        endfunction

        function bit vehicle(bit pin);
            return loop_pol ? pin : !pin;
        endfunction

        function void timer_expired(bit lp);
            fault_q = F_NONE;
            if (mode_q == M_OPENING)
            begin
                mode_q = M_OPEN;
                hold_q = clamp16(hold_t);
                relays_off();
                start_timer(hold_t);
                timed_q = 1;
            end
            else if (mode_q == M_OPEN)
            begin
                if (!vehicle(lp))
                begin
                    mode_q = M_CLOSING;
                    drive(RLY_DOWN);
                    elapsed = 0;
                    timed_q = 0;
                    start_timer(close_t);
                end
                else
                begin
                    hold_q = clamp16(hold_t);
                    restart_timer();
                end
            end
            else if (mode_q == M_CLOSING)
            begin
                mode_q = M_IDLE;
                relays_off();
                timed_q = 1;
            end
        endfunction

        function void raise_request();
            int unsigned up_t, dn_t, e, eo, rem;
            fault_q = F_NONE;
            if (mode_q == M_ERROR || mode_q == M_OPENING)
                return;
            hold_q = clamp16(hold_t);
            if (mode_q == M_OPEN)
            begin
                restart_timer();
                return;
            end
            tmr_run = 0;
            up_t = travel(lrn_up, open_t);
            if (mode_q == M_CLOSING)
            begin
                dn_t = travel(lrn_dn, close_t);
                e = (elapsed > dn_t) ? dn_t : elapsed;
                eo = int'((longint'(e) * longint'(up_t)) / longint'(dn_t));
                rem = up_t - eo;
                elapsed = eo;
                start_timer(rem < 100 ? 100 : rem);
            end
            else
            begin
                elapsed = 0;
                start_timer(up_t);
            end
            mode_q = M_OPENING;
            drive(RLY_UP);
            timed_q = 0;
        endfunction

        function void at_top();
            ind_q = 1;
            fault_q = F_NONE;
            if (mode_q == M_CLOSING)
                return;
            if (elapsed > 0 && elapsed < 60000)
                lrn_up = elapsed;
            mode_q = M_OPEN;
            hold_q = clamp16(hold_t);
            relays_off();
            start_timer(hold_t);
        endfunction

        function void at_bottom();
            ind_q = 0;
            fault_q = F_NONE;
            if (mode_q == M_CLOSING)
            begin
                if (elapsed > 0 && elapsed < 60000)
                    lrn_dn = elapsed;
                mode_q = M_IDLE;
                relays_off();
                tmr_run = 0;
            end
            else if (mode_q != M_OPENING)
            begin
                mode_q = M_IDLE;
                relays_off();
            end
        endfunction

        function int unsigned percent();
            longint unsigned p;
            if (mode_q == M_OPEN)
                return 100;
            if (mode_q == M_OPENING)
            begin
                p = (longint'(elapsed) * 100) / travel(lrn_up, open_t);
                return (p > 100) ? 100 : int'(p);
            end
            if (mode_q == M_CLOSING)
            begin
                p = (longint'(elapsed) * 100) / travel(lrn_dn, close_t);
                return (p > 100) ? 0 : 100 - int'(p);
            end
            return 0;
        endfunction

        function void note_tick(logic [4:0] pins);
            bit b1, b2, lp, up, dn, up_chg, dn_chg;
            int unsigned chg, hold_out, pos;
            gate_status_t s;
            b1 = pins[0]; b2 = pins[1]; lp = pins[2]; up = pins[3]; dn = pins[4];
            chg = pins_seen ? (pins ^ last_pins) : 5'h1f;
            hold_out = 0;
            if (since_sw < 65535) since_sw++;
            if (elapsed < 131071) elapsed++;
            if (hold_q > 0) hold_q--;
            if (tmr_run)
            begin
                if (tmr_left > 0) tmr_left--;
                if (tmr_left == 0)
                begin
                    tmr_run = 0;
                    timer_expired(lp);
                end
            end
            if (pending && since_sw >= dead_t)
            begin
                if (mode_q == M_OPENING && !relays[0])
                begin
                    if (relays[1]) begin relays = RLY_OFF; since_sw = 0; end
                    else begin relays = RLY_UP; pending = 0; end
                end
                else if (mode_q == M_CLOSING && !relays[1])
                begin
                    if (relays[0]) begin relays = RLY_OFF; since_sw = 0; end
                    else begin relays = RLY_DOWN; pending = 0; end
                end
                else
                    pending = 0;
            end
            if (chg[0] && !b1) raise_request();
            if (chg[1] && !b2) raise_request();
            if (chg[2])
            begin
                if (vehicle(lp) && dn) raise_request();
                if (!vehicle(lp))
                begin
                    hold_q = clamp16(hold_t);
                    restart_timer();
                end
            end
            up_chg = chg[3];
            dn_chg = chg[4];
            if ((up_chg || dn_chg) && mode_q == M_ERROR)
            begin
                up_chg = 1;
                dn_chg = 1;
            end
            if (up_chg)
            begin
                if (!up && dn) at_top();
                if (!up && !dn) trip(F_BOTH_LIMITS);
            end
            if (dn_chg)
            begin
                if (!dn && up) at_bottom();
                if (!up && !dn) trip(F_BOTH_LIMITS);
            end
            last_pins = pins;
            pins_seen = 1;
            pos = percent();
            if (fault_q == F_NONE)
            begin
                if (mode_q == M_OPEN && !vehicle(lp))
                    hold_out = hold_q;
                else if (mode_q == M_OPENING && up && elapsed > open_t + 2000)
                    trip(F_STUCK_OPEN);
                else if (mode_q == M_CLOSING && dn && !vehicle(lp) &&
                         elapsed > close_t + 2000)
                    trip(F_STUCK_CLOSE);
            end
            s.drive_up = relays[0];
            s.drive_down = relays[1];
            s.indicator = ind_q[0];
            s.mode = mode_q[2:0];
            s.fault = fault_q[1:0];
            s.position = pos[6:0];
            s.hold_left = hold_out[15:0];
            s.learned_up = lrn_up[15:0];
            s.learned_down = lrn_dn[15:0];
            s.timed_finish = timed_q[0];
            status_q.push_back(s);
        endfunction

        function void report(string what, int unsigned got, int unsigned want);
            $display("mismatch on %s at status %0d: got %0d, expected %0d",
                     what, checked, got, want);
            errors++;
        endfunction

        function void check_status(logic [63:0] d);
            gate_status_t w;
            if (status_q.size() == 0)
            begin
                $display("status word %h arrived with no tick outstanding", d);
                errors++;
                return;
            end
            w = status_q.pop_front();
            if (d[0] !== w.drive_up) report("drive_up", d[0], w.drive_up);
            if (d[1] !== w.drive_down) report("drive_down", d[1], w.drive_down);
            if (d[2] !== w.indicator) report("indicator", d[2], w.indicator);
            if (d[5:3] !== w.mode) report("mode", d[5:3], w.mode);
            if (d[7:6] !== w.fault) report("fault", d[7:6], w.fault);
            if (d[14:8] !== w.position) report("position", d[14:8], w.position);
            if (d[30:15] !== w.hold_left) report("hold_left", d[30:15], w.hold_left);
            if (d[46:31] !== w.learned_up) report("learned_up", d[46:31], w.learned_up);
            if (d[62:47] !== w.learned_down)
                report("learned_down", d[62:47], w.learned_down);
            if (d[63] !== w.timed_finish) report("timed_finish", d[63], w.timed_finish);
            checked++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    gate_scoreboard sb;
    bit   steady;
    logic [4:0] pins;
    int   ticks_sent;
    int   settings_used;

    barrier_gate_motor_controller dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #20ms;
        $display("FAIL");
        $finish;
    end

    task automatic send_tick(logic [4:0] p);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, p};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_tick(p);
        ticks_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.status_q.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    task automatic apply_settings(int unsigned o, int unsigned c, int unsigned h,
                                  int unsigned pol, int unsigned dt);
        settle();
        write_reg(CFG_OPEN_TIME, o[15:0]);
        write_reg(CFG_CLOSE_TIME, c[15:0]);
        write_reg(CFG_OPEN_HOLD, h[15:0]);
        write_reg(CFG_LOOP_POL, pol[15:0]);
        write_reg(CFG_DEAD_TIME, dt[15:0]);
        settings_used++;
    endtask

    // Pins follow a rough plant: limits arrive while moving, buttons pulse, loop toggles.
    task automatic run_traffic(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 49) == 0)
                steady = !steady;
            pins[1:0] = 2'b11;
            if ($urandom_range(0, 24) == 0)
                pins[$urandom_range(0, 1)] = 1'b0;
            if ($urandom_range(0, 39) == 0)
                pins[2] = !pins[2];
            if (sb.mode_q == M_OPENING)
            begin
                pins[4] = 1'b1;
                if ($urandom_range(0, 14) == 0) pins[3] = 1'b0;
            end
            else if (sb.mode_q == M_CLOSING)
            begin
                pins[3] = 1'b1;
                if ($urandom_range(0, 14) == 0) pins[4] = 1'b0;
            end
            if ($urandom_range(0, 59) == 0)
                pins[$urandom_range(0, 4)] ^= 1'b1;
            send_tick(pins);
        end
    endtask

    always
    begin : status_sink
        int gap;
        gap = steady ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            m_axis_tready <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        m_axis_tready <= 1'b1;
        do @(posedge clk); while (!m_axis_tvalid);
        sb.check_status(m_axis_tdata);
        @(negedge clk);
    end

    initial
    begin
        sb = new();
        steady = 1'b0;
        ticks_sent = 0;
        settings_used = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // first tick sees every pin as changed; then edges, loop, limits, both limits
        send_tick(5'b11011);
        send_tick(5'b11010);
        send_tick(5'b11011);
        send_tick(5'b11001);
        send_tick(5'b11011);
        send_tick(5'b10011);
        send_tick(5'b11111);
        send_tick(5'b11011);
        send_tick(5'b01011);
        send_tick(5'b00011);
        send_tick(5'b10011);
        send_tick(5'b10111);
        send_tick(5'b10000);
        send_tick(5'b11111);
        send_tick(5'b01011);
        send_tick(5'b11011);

        apply_settings(20, 25, 15, 0, 3);
        pins = 5'b11011;
        run_traffic(220);
        apply_settings(1, 1, 1, 1, 0);
        run_traffic(160);
        apply_settings(40, 30, 60, 0, 1000);
        run_traffic(180);
        apply_settings(60000, 60000, 60000, 1, 50);
        run_traffic(80);
        apply_settings(8, 12, 30, 1, 10);
        run_traffic(300);
        apply_settings(15, 9, 5, 0, 0);
        run_traffic(280);

        s_axis_tvalid <= 1'b0;
        while (sb.status_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("%0d ticks under %0d settings, %0d status words checked, %0d mismatches",
                 ticks_sent, settings_used, sb.checked, sb.errors);
        if (sb.errors == 0 && sb.status_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
